@@ hdl/hsv_pkg.sv @@
// shared types, constants and helpers for the hsv to rgb pixel pipeline
// no dependencies; used by hsv_front, hsv_div_lane, hsv_core and the top level
package hsv_pkg;

  localparam int HUE_W   = 15;
  localparam int CH_W    = 8;
  localparam int FRAC_W  = 12;
  localparam int PROD_W  = 20;
  localparam int Y_W     = 28;
  localparam int RECIP_W = 21;
  localparam int E_W     = Y_W + RECIP_W;
  localparam int RECIP_SHIFT = 40;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // one 60 degree sector in 1/64 degree units, and a full turn
  localparam logic [FRAC_W-1:0] SECTOR_UNITS = FRAC_W'(3840);
  localparam logic [HUE_W-1:0]  FULL_TURN    = HUE_W'(23040);
  // 255 * 3840, the common denominator of p, q and t
  localparam logic [PROD_W-1:0] SCALE        = PROD_W'(979200);
  // floor(2^40 / SCALE), estimate is low by at most one
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd979200);

  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } hsv_sector_t;

  // payload handed from the front stages to the divider lanes
  typedef struct packed {
    hsv_sector_t             sector;
    logic [CH_W-1:0]         bright;
    logic [PROD_W-1:0]       prod_p;
    logic [PROD_W-1:0]       prod_q;
    logic [PROD_W-1:0]       prod_t;
  } hsv_prod_t;

  // start of each sector in hue units
  function automatic logic [HUE_W-1:0] sector_base(input hsv_sector_t sec);
    logic [HUE_W-1:0] base;
    case (sec)
      SECT_YEL_GRN: base = HUE_W'(3840);
      SECT_GRN_CYN: base = HUE_W'(7680);
      SECT_CYN_BLU: base = HUE_W'(11520);
      SECT_BLU_MAG: base = HUE_W'(15360);
      SECT_MAG_RED: base = HUE_W'(19200);
      default:      base = HUE_W'(0);
    endcase
    return base;
  endfunction

endpackage

@@ hdl/hsv_front.sv @@
// front stages: hue wrap, sector/fraction split and saturation products
// depends on hsv_pkg
module hsv_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hsv_pkg::HUE_W-1:0]     hue_i,
  input  logic [hsv_pkg::CH_W-1:0]      sat_i,
  input  logic [hsv_pkg::CH_W-1:0]      bright_i,
  output logic                          prod_valid_o,
  input  logic                          prod_ready_i,
  output hsv_pkg::hsv_prod_t            prod_o
);
  import hsv_pkg::*;

  logic [2:0] vld_r;
  logic [3:0] adv;

  logic [HUE_W-1:0]  h0_r, h0_nxt;
  logic [CH_W-1:0]   s0_r, v0_r;
  hsv_sector_t       sec1_r, sec1_nxt;
  logic [FRAC_W-1:0] frac1_r, frac1_nxt;
  logic [CH_W-1:0]   s1_r, v1_r;
  hsv_prod_t         prod_r, prod_nxt;

  // a stage takes new data when empty or when its content moves on
  always_comb begin
    adv[3] = prod_ready_i;
    for (int k = 2; k >= 0; k--) begin
      adv[k] = ~vld_r[k] | adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid_i;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
    end
  end

  // hues of a full turn or more wrap once
  assign h0_nxt = (hue_i >= FULL_TURN) ? HUE_W'(hue_i - FULL_TURN) : hue_i;

  always_comb begin
    sec1_nxt = SECT_RED_YEL;
    for (int k = 1; k < 6; k++) begin
      if (h0_r >= HUE_W'(k * 3840)) sec1_nxt = hsv_sector_t'(3'(k));
    end
    frac1_nxt = FRAC_W'(h0_r - sector_base(sec1_nxt));
  end

  always_comb begin
    prod_nxt.sector = sec1_r;
    prod_nxt.bright = v1_r;
    prod_nxt.prod_p = PROD_W'(s1_r) * PROD_W'(SECTOR_UNITS);
    prod_nxt.prod_q = PROD_W'(s1_r) * PROD_W'(frac1_r);
    prod_nxt.prod_t = PROD_W'(s1_r) * PROD_W'(FRAC_W'(SECTOR_UNITS - frac1_r));
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      h0_r <= h0_nxt;
      s0_r <= sat_i;
      v0_r <= bright_i;
    end
    if (adv[1]) begin
      sec1_r  <= sec1_nxt;
      frac1_r <= frac1_nxt;
      s1_r    <= s0_r;
      v1_r    <= v0_r;
    end
    if (adv[2]) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_valid_o = vld_r[2];
  assign prod_o       = prod_r;

endmodule

@@ hdl/hsv_div_lane.sv @@
// one divider lane: floor(v * (SCALE - prod) / SCALE) over five stages
// reciprocal multiply with a single correction step; depends on hsv_pkg
module hsv_div_lane (
  input  logic                          clk,
  input  logic [4:0]                    adv_i,
  input  logic [hsv_pkg::PROD_W-1:0]    prod_i,
  input  logic [hsv_pkg::CH_W-1:0]      bright_i,
  output logic [hsv_pkg::CH_W-1:0]      res_o
);
  import hsv_pkg::*;

  logic [PROD_W-1:0] n_r;
  logic [Y_W-1:0]    y_r, y2_r, y3_r, qp_r;
  logic [E_W-1:0]    est;
  logic [CH_W-1:0]   qe_r, qe2_r, res_r;
  logic              corr;

  assign est  = E_W'(y_r) * E_W'(RECIP);
  // estimate is at most one low
  assign corr = ({1'b0, y3_r} >= ({1'b0, qp_r} + (Y_W+1)'(SCALE)));

  always_ff @(posedge clk) begin
    if (adv_i[0]) n_r <= PROD_W'(SCALE - prod_i);
    if (adv_i[1]) y_r <= Y_W'(bright_i) * Y_W'(n_r);
    if (adv_i[2]) begin
      qe_r <= est[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
      y2_r <= y_r;
    end
    if (adv_i[3]) begin
      qp_r  <= Y_W'(qe_r) * Y_W'(SCALE);
      qe2_r <= qe_r;
      y3_r  <= y2_r;
    end
    if (adv_i[4]) res_r <= qe2_r + CH_W'(corr);
  end

  assign res_o = res_r;

endmodule

@@ hdl/hsv_core.sv @@
// divider lanes for p, q and t, sector select and output register
// depends on hsv_pkg and hsv_div_lane
module hsv_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              prod_valid_i,
  output logic                              prod_ready_o,
  input  hsv_pkg::hsv_prod_t                prod_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [hsv_pkg::OUT_DATA_W-1:0]    out_data_o
);
  import hsv_pkg::*;

  logic [5:0]      vld_r;
  logic [6:0]      adv;
  hsv_sector_t     sec_r [5];
  logic [CH_W-1:0] v_r   [5];
  logic [CH_W-1:0] res_p, res_q, res_t;
  logic [CH_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic [OUT_DATA_W-1:0] data_r;

  always_comb begin
    adv[6] = out_ready_i;
    for (int k = 5; k >= 0; k--) begin
      adv[k] = ~vld_r[k] | adv[k+1];
    end
  end

  assign prod_ready_o = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= prod_valid_i;
      for (int k = 1; k < 6; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // sector and brightness ride along with the lanes
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sec_r[0] <= prod_i.sector;
      v_r[0]   <= prod_i.bright;
    end
    for (int k = 1; k < 5; k++) begin
      if (adv[k]) begin
        sec_r[k] <= sec_r[k-1];
        v_r[k]   <= v_r[k-1];
      end
    end
  end

  hsv_div_lane u_lane_p (
    .clk      (clk),
    .adv_i    (adv[4:0]),
    .prod_i   (prod_i.prod_p),
    .bright_i (v_r[0]),
    .res_o    (res_p)
  );

  hsv_div_lane u_lane_q (
    .clk      (clk),
    .adv_i    (adv[4:0]),
    .prod_i   (prod_i.prod_q),
    .bright_i (v_r[0]),
    .res_o    (res_q)
  );

  hsv_div_lane u_lane_t (
    .clk      (clk),
    .adv_i    (adv[4:0]),
    .prod_i   (prod_i.prod_t),
    .bright_i (v_r[0]),
    .res_o    (res_t)
  );

  always_comb begin
    case (sec_r[4])
      SECT_YEL_GRN: begin red_nxt = res_q;   green_nxt = v_r[4]; blue_nxt = res_p;  end
      SECT_GRN_CYN: begin red_nxt = res_p;   green_nxt = v_r[4]; blue_nxt = res_t;  end
      SECT_CYN_BLU: begin red_nxt = res_p;   green_nxt = res_q;  blue_nxt = v_r[4]; end
      SECT_BLU_MAG: begin red_nxt = res_t;   green_nxt = res_p;  blue_nxt = v_r[4]; end
      SECT_MAG_RED: begin red_nxt = v_r[4];  green_nxt = res_p;  blue_nxt = res_q;  end
      default:      begin red_nxt = v_r[4];  green_nxt = res_t;  blue_nxt = res_p;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[5]) data_r <= {blue_nxt, green_nxt, red_nxt};
  end

  assign out_valid_o = vld_r[5];
  assign out_data_o  = data_r;

  // p, q and t never exceed the value channel
  a_lane_le_v: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (res_p <= v_r[4]) && (res_q <= v_r[4]) && (res_t <= v_r[4]))
    else $error("lane result above value");

  // p uses the full sector width, so it is never above q or t
  a_p_lowest: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (res_p <= res_q) && (res_p <= res_t))
    else $error("p above q or t");

  // a held stage keeps its beat and its sector
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && !adv[4]) |=> vld_r[4] && $stable(sec_r[4]))
    else $error("stalled stage lost its beat");

  // a new output beat comes only from a filled last lane stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vld_r[5]) |-> $past(vld_r[4]))
    else $error("output beat without source");

endmodule

@@ hdl/hsv_to_rgb_converter.sv @@
// hsv to rgb pixel converter, fixed point, one pixel per beat
// throughput one beat per cycle while the output is not stalled
// the rate is set by a fully pipelined datapath: 3 front stages, 5 divider stages, 1 output
// a stall holds each full stage; empty stages still fill, so input is taken while output waits until all are full
// reset (synchronous, active low) clears only the stage valid bits; the data registers are not reset
// depends on hsv_pkg, hsv_front, hsv_core
module hsv_to_rgb_converter (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hsv_pkg::IN_DATA_W-1:0]     in_tdata,   // hue[14:0], saturation[22:15],
                                                        // brightness[30:23], zero[31]
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hsv_pkg::OUT_DATA_W-1:0]    out_tdata   // red[7:0], green[15:8], blue[23:16]
);
  import hsv_pkg::*;

  logic      mid_valid;
  logic      mid_ready;
  hsv_prod_t mid_prod;

  // unpack the input beat; the pad bit is ignored
  logic [HUE_W-1:0] hue;
  logic [CH_W-1:0]  saturation;
  logic [CH_W-1:0]  brightness;

  assign hue        = in_tdata[HUE_W-1:0];
  assign saturation = in_tdata[HUE_W+CH_W-1:HUE_W];
  assign brightness = in_tdata[HUE_W+2*CH_W-1:HUE_W+CH_W];

  // hue wrap, sector split and the three saturation products
  hsv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid_i   (in_tvalid),
    .in_ready_o   (in_tready),
    .hue_i        (hue),
    .sat_i        (saturation),
    .bright_i     (brightness),
    .prod_valid_o (mid_valid),
    .prod_ready_i (mid_ready),
    .prod_o       (mid_prod)
  );

  // p, q, t through reciprocal divider lanes, then the six-sector select
  hsv_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .prod_valid_i (mid_valid),
    .prod_ready_o (mid_ready),
    .prod_i       (mid_prod),
    .out_valid_o  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_data_o   (out_tdata)
  );

endmodule
